>>> src/aid_pkg.sv
// Shared types and constants for the array intersection unit.
// No dependencies; compile this file first.
`default_nettype none

package aid_pkg;

    localparam int VAL_W  = 7;
    localparam int FUNC_W = 2;

    // Operation carried by an input beat.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_RUN    = 2'd2
    } t_func;

endpackage

`default_nettype wire

>>> src/aid_if.sv
// Valid/ready channel interfaces for the input and result streams.
// Depends on aid_pkg for the field widths.
`default_nettype none

interface aid_in_if;
    import aid_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [VAL_W-1:0]  value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface aid_out_if;
    import aid_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] common_value;
    logic             found;
    logic             last;

    modport source (output valid, output common_value, output found, output last,
                    input ready);
    modport sink   (input valid, input common_value, input found, input last,
                    output ready);
endinterface

`default_nettype wire

>>> src/array_intersection_dedup_unit.sv
// Loads are accepted back to back while idle. A run beat walks the first array in load
// order; each element is fetched (S_FETCH) and checked against the values already
// found (S_CHECK), and if it is new, the second array is read and compared element by
// element (S_SCAN), stopping at the first match. A match passes through S_PUSH to hand
// the result over. The single compare on the second array's read port bounds run time.
// Input is held off until the last result has been loaded.
// Depends on aid_pkg, aid_if and aid_mem.
`default_nettype none

module array_intersection_dedup_unit #(
    parameter int DEPTH       = 32,
    parameter int VALUE_RANGE = 128
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    aid_in_if.sink     i_in_ch,
    aid_out_if.source  o_out_ch
);
    import aid_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SEEN_N = (VALUE_RANGE < (1 << VAL_W)) ? VALUE_RANGE : (1 << VAL_W);
    localparam int SEEN_W = $clog2(SEEN_N);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_SCAN,
        S_PUSH,
        S_FINAL
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_fc, n_fc;
    logic [CNT_W-1:0]  r_sc, n_sc;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_j, n_j;
    logic              r_cmp_vld, n_cmp_vld;
    logic              r_issue_done, n_issue_done;
    logic [SEEN_N-1:0] r_seen, n_seen;
    logic              r_have_pend, n_have_pend;
    logic [VAL_W-1:0]  r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    logic [VAL_W-1:0]  r_out_val, n_out_val;
    logic              r_out_found, n_out_found;
    logic              r_out_last, n_out_last;

    logic              accept;
    logic              val_ok;
    logic              a_we, b_we;
    logic [VAL_W-1:0]  a_rdata, b_rdata;
    logic              out_free;
    logic              last_i;
    logic              match;

    aid_mem #(.DEPTH(DEPTH)) u_first (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (r_fc[IDX_W-1:0]),
        .i_wdata (i_in_ch.value),
        .i_raddr (r_i),
        .o_rdata (a_rdata)
    );

    aid_mem #(.DEPTH(DEPTH)) u_second (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (r_sc[IDX_W-1:0]),
        .i_wdata (i_in_ch.value),
        .i_raddr (r_j),
        .o_rdata (b_rdata)
    );

    assign i_in_ch.ready         = (r_state == S_IDLE);
    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.common_value = r_out_val;
    assign o_out_ch.found        = r_out_found;
    assign o_out_ch.last         = r_out_last;

    assign accept   = i_in_ch.valid && (r_state == S_IDLE);
    assign val_ok   = (32'(i_in_ch.value) < VALUE_RANGE);
    assign a_we     = accept && (t_func'(i_in_ch.func) == FUNC_LOAD_A)
                      && (r_fc < CNT_W'(DEPTH)) && val_ok;
    assign b_we     = accept && (t_func'(i_in_ch.func) == FUNC_LOAD_B)
                      && (r_sc < CNT_W'(DEPTH)) && val_ok;
    assign out_free = !r_out_valid || o_out_ch.ready;
    assign last_i   = ((CNT_W'(r_i) + CNT_W'(1)) == r_fc);
    assign match    = r_cmp_vld && (b_rdata == a_rdata);

    always_comb begin
        n_state      = r_state;
        n_fc         = r_fc;
        n_sc         = r_sc;
        n_i          = r_i;
        n_j          = r_j;
        n_cmp_vld    = 1'b0;
        n_issue_done = r_issue_done;
        n_seen       = r_seen;
        n_have_pend  = r_have_pend;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !o_out_ch.ready;
        n_out_val    = r_out_val;
        n_out_found  = r_out_found;
        n_out_last   = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (a_we) begin
                    n_fc = r_fc + CNT_W'(1);
                end
                if (b_we) begin
                    n_sc = r_sc + CNT_W'(1);
                end
                if (accept && (t_func'(i_in_ch.func) == FUNC_RUN)) begin
                    n_seen      = '0;
                    n_have_pend = 1'b0;
                    n_i         = '0;
                    if ((r_fc == '0) || (r_sc == '0)) begin
                        n_state = S_FINAL;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_seen[a_rdata[SEEN_W-1:0]]) begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = last_i ? S_FINAL : S_FETCH;
                end else begin
                    n_j          = '0;
                    n_issue_done = 1'b0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                // Reads are issued one a cycle; each compare sees the previous read.
                if (!r_issue_done) begin
                    n_cmp_vld = 1'b1;
                    n_j       = r_j + IDX_W'(1);
                    if ((CNT_W'(r_j) + CNT_W'(1)) == r_sc) begin
                        n_issue_done = 1'b1;
                    end
                end
                if (match) begin
                    n_seen[a_rdata[SEEN_W-1:0]] = 1'b1;
                    n_state = S_PUSH;
                end else if (r_issue_done) begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = last_i ? S_FINAL : S_FETCH;
                end
            end
            S_PUSH: begin
                // A result waits in r_pend until the next one shows it was not the last.
                if (!r_have_pend || out_free) begin
                    if (r_have_pend) begin
                        n_out_valid = 1'b1;
                        n_out_val   = r_pend;
                        n_out_found = 1'b1;
                        n_out_last  = 1'b0;
                    end
                    n_pend      = a_rdata;
                    n_have_pend = 1'b1;
                    n_i         = r_i + IDX_W'(1);
                    n_state     = last_i ? S_FINAL : S_FETCH;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    if (r_have_pend) begin
                        n_out_val   = r_pend;
                        n_out_found = 1'b1;
                    end else begin
                        n_out_val   = '0;
                        n_out_found = 1'b0;
                    end
                    n_fc    = '0;
                    n_sc    = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fc         <= '0;
            r_sc         <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_cmp_vld    <= 1'b0;
            r_issue_done <= 1'b0;
            r_seen       <= '0;
            r_have_pend  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fc         <= n_fc;
            r_sc         <= n_sc;
            r_i          <= n_i;
            r_j          <= n_j;
            r_cmp_vld    <= n_cmp_vld;
            r_issue_done <= n_issue_done;
            r_seen       <= n_seen;
            r_have_pend  <= n_have_pend;
            r_out_valid  <= n_out_valid;
        end
        r_pend      <= n_pend;
        r_out_val   <= n_out_val;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
    end

endmodule

`default_nettype wire

>>> src/aid_mem.sv
// Element store: one write port and one registered read port.
// Depends on aid_pkg for the element width.
`default_nettype none

module aid_mem #(
    parameter int DEPTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  wire logic [aid_pkg::VAL_W-1:0]     i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]      i_raddr,
    output logic      [aid_pkg::VAL_W-1:0]     o_rdata
);
    import aid_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> test/tb_array_intersection_dedup_unit.sv
// Self-checking testbench for array_intersection_dedup_unit: directed table plus random
// load/run sequences, checked against a behavioral predictor of the intersection.
// Depends on aid_pkg, aid_if and the unit under test in src.
`timescale 1ns / 100ps

module tb_array_intersection_dedup_unit;
    import aid_pkg::*;

    localparam int DEPTH        = 32;
    localparam int VALUE_RANGE  = 128;
    localparam int RANDOM_ITEMS = 240;
    localparam int DRAIN_CYCLES = 1300;
    localparam int LIMIT_CYCLES = 1_000_000;

    // The selector code that the unit must ignore.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0] common_value;
        logic             found;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [VAL_W-1:0]  value;
        logic [5:0]        reps;
        logic              descend;
        logic              typed;
        t_result           want;
    } t_row;

    localparam t_result NO_HIT = '{common_value: '0, found: 1'b0, last: 1'b1};
    localparam t_result ONLY_85 = '{common_value: 7'd85, found: 1'b1, last: 1'b1};
    localparam t_result NONE = '{common_value: '0, found: 1'b0, last: 1'b0};

    // Rows with reps above one load value, value +/- 1, ... in a burst.
    localparam int NUM_ROWS = 24;
    localparam t_row DIR_ROWS [0:NUM_ROWS-1] = '{
        '{FUNC_RUN,    7'h55,  6'd1,  1'b0, 1'b1, NO_HIT},
        '{FUNC_LOAD_A, 7'd127, 6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_RUN,    7'd0,   6'd1,  1'b0, 1'b1, NO_HIT},
        '{FUNC_LOAD_B, 7'd5,   6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_RUN,    7'd127, 6'd1,  1'b0, 1'b1, NO_HIT},
        '{FUNC_LOAD_A, 7'd0,   6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_LOAD_A, 7'd127, 6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_LOAD_A, 7'd0,   6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_UNUSED, 7'd127, 6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_LOAD_B, 7'd127, 6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_LOAD_B, 7'd0,   6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_LOAD_B, 7'd127, 6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_RUN,    7'd0,   6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_LOAD_A, 7'd42,  6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_LOAD_B, 7'd85,  6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_RUN,    7'd0,   6'd1,  1'b0, 1'b1, NO_HIT},
        '{FUNC_LOAD_A, 7'd85,  6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_LOAD_B, 7'd85,  6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_RUN,    7'd42,  6'd1,  1'b0, 1'b1, ONLY_85},
        '{FUNC_LOAD_A, 7'd0,   6'd34, 1'b0, 1'b0, NONE},
        '{FUNC_LOAD_B, 7'd33,  6'd34, 1'b1, 1'b0, NONE},
        '{FUNC_RUN,    7'd127, 6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_UNUSED, 7'd0,   6'd1,  1'b0, 1'b0, NONE},
        '{FUNC_RUN,    7'd0,   6'd1,  1'b0, 1'b1, NO_HIT}
    };

    logic i_clk;
    logic i_rst_n;

    aid_in_if  in_ch ();
    aid_out_if out_ch ();

    array_intersection_dedup_unit #(
        .DEPTH       (DEPTH),
        .VALUE_RANGE (VALUE_RANGE)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    // Predictor state.
    logic [VAL_W-1:0] set_a [DEPTH];
    logic [VAL_W-1:0] set_b [DEPTH];
    int               count_a;
    int               count_b;
    t_result          pending_results [$];

    int err_cnt;
    int cycle_cnt = 0;
    int sent_beats;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Updates the arrays for one accepted beat and, for a run, queues its results when push is set.
    task automatic predict_intersection(input logic [FUNC_W-1:0] func,
                                        input logic [VAL_W-1:0] value, input bit push);
        logic [VALUE_RANGE-1:0] seen;
        t_result                hits [$];
        t_result                r;
        bit                     hit;
        if (func == FUNC_LOAD_A) begin
            if (count_a < DEPTH) begin
                set_a[count_a] = value;
                count_a++;
            end
        end else if (func == FUNC_LOAD_B) begin
            if (count_b < DEPTH) begin
                set_b[count_b] = value;
                count_b++;
            end
        end else if (func == FUNC_RUN) begin
            seen = '0;
            for (int i = 0; i < count_a; i++) begin
                if (!seen[set_a[i]]) begin
                    hit = 1'b0;
                    for (int j = 0; j < count_b; j++) begin
                        if (set_b[j] == set_a[i])
                            hit = 1'b1;
                    end
                    if (hit) begin
                        seen[set_a[i]] = 1'b1;
                        r = '{common_value: set_a[i], found: 1'b1, last: 1'b0};
                        hits.push_back(r);
                    end
                end
            end
            if (hits.size() == 0)
                hits.push_back(NO_HIT);
            else
                hits[hits.size()-1].last = 1'b1;
            if (push) begin
                foreach (hits[k])
                    pending_results.push_back(hits[k]);
            end
            count_a = 0;
            count_b = 0;
        end
    endtask

    // Presents one beat after an optional gap and returns at the edge that accepts it.
    task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [VAL_W-1:0] value,
                             input bit typed, input t_result want);
        int gap;
        gap = ((sent_beats / 48) % 4 == 3) ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func  <= func;
        in_ch.value <= value;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        sent_beats++;
        predict_intersection(func, value, !typed);
        if (typed)
            pending_results.push_back(want);
    endtask

    function automatic logic [VAL_W-1:0] pick_value(input bit windowed,
                                                    input logic [VAL_W-1:0] base,
                                                    input int span);
        if (windowed)
            return base + VAL_W'($urandom_range(0, span - 1));
        return VAL_W'($urandom_range(0, VALUE_RANGE - 1));
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, DEPTH + 4);
        return $urandom_range(0, 8);
    endfunction

    // Result side: check at each accepting edge, then choose ready for the next cycle.
    initial begin : result_sink
        int      stall_left;
        t_result want;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $display("[%0t] result beat with nothing expected: value %0d found %0b",
                             $time, out_ch.common_value, out_ch.found);
                    err_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.common_value !== want.common_value)
                        report_mismatch("common_value", out_ch.common_value,
                                        want.common_value);
                    if (out_ch.found !== want.found)
                        report_mismatch("found", out_ch.found, want.found);
                    if (out_ch.last !== want.last)
                        report_mismatch("last", out_ch.last, want.last);
                end
            end
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if ((cycle_cnt / 700) % 4 != 2)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin : stimulus
        t_row             row;
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] base;
        int               items;
        int               kind;
        int               na;
        int               nb;
        int               span;
        bit               windowed;
        logic [FUNC_W-1:0] f;

        err_cnt    = 0;
        sent_beats = 0;
        count_a    = 0;
        count_b    = 0;
        items      = 0;
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.func  <= FUNC_LOAD_A;
        in_ch.value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_ROWS[n]) begin
            row = DIR_ROWS[n];
            for (int k = 0; k < row.reps; k++) begin
                v = row.descend ? row.value - VAL_W'(k) : row.value + VAL_W'(k);
                send_beat(row.func, v, row.typed, row.want);
            end
        end

        while (items < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                // Noise: any selector with any value, including the ignored one.
                f = FUNC_W'($urandom_range(0, 3));
                send_beat(f, VAL_W'($urandom_range(0, VALUE_RANGE - 1)), 1'b0, NONE);
                if (f != FUNC_UNUSED)
                    items++;
            end else begin
                na       = pick_len();
                nb       = pick_len();
                windowed = ($urandom_range(0, 3) != 0);
                base     = VAL_W'($urandom_range(0, VALUE_RANGE - 1));
                span     = $urandom_range(1, 16);
                while (na > 0 || nb > 0) begin
                    if ($urandom_range(0, 19) == 0)
                        send_beat(FUNC_UNUSED, pick_value(0, base, span), 1'b0, NONE);
                    if (na > 0 && (nb == 0 || $urandom_range(0, 1) == 0)) begin
                        send_beat(FUNC_LOAD_A, pick_value(windowed, base, span), 1'b0, NONE);
                        na--;
                    end else begin
                        send_beat(FUNC_LOAD_B, pick_value(windowed, base, span), 1'b0, NONE);
                        nb--;
                    end
                    items++;
                end
                send_beat(FUNC_RUN, VAL_W'($urandom_range(0, VALUE_RANGE - 1)), 1'b0, NONE);
                items++;
            end
        end
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
